/* rtl/core/lesq_pkg.sv */
// shared types and constants for the largest empty square scan unit
`timescale 1ns / 1ps

package lesq_pkg;

    localparam int SYM_W     = 8;
    localparam int SIDE_W    = 11;
    localparam int LEN_W     = 11;
    localparam int ROW_OUT_W = 16;
    localparam int COL_OUT_W = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH    = 2'd2;

    localparam logic [SYM_W-1:0] SYM_NEWLINE = 8'h0A;
    localparam logic [SYM_W-1:0] SYM_NUL     = 8'h00;

    localparam logic [SYM_W-1:0] OBSTACLE_RESET = 8'd111;
    localparam logic [SYM_W-1:0] EMPTY_RESET    = 8'd46;
    localparam logic [LEN_W-1:0] LENGTH_RESET   = 11'd1;

    typedef enum logic [1:0] {
        K_CELL_OBS   = 2'd0,
        K_CELL_EMPTY = 2'd1,
        K_TERM_OK    = 2'd2,
        K_TERM_BAD   = 2'd3
    } t_kind;

endpackage

/* rtl/core/largest_empty_square_scan_unit.sv */
// largest empty square scan unit: row buffer, square side and best square tracking
`timescale 1ns / 1ps

// Takes one map character per cycle while not stalled, and returns one result item per
// character. The row buffer (a single memory with one write and one read port, one
// entry per column) is read at the edge that accepts an item; in the following cycle
// the side is computed and the best square updated, and both are loaded into the
// output register when the compute stage advances. The rate is set by the row
// buffer read-modify-write, which completes one column per cycle while the output
// is not stalled; a read of the column written in the same cycle takes the
// forwarded value. The input stalls only while the output register holds a stalled
// result and the compute stage is full. The row buffer needs no clearing pass after
// reset: row 0 ignores what it reads. Configuration writes are always ready and must
// be made only while the unit is idle.
module largest_empty_square_scan_unit
    import lesq_pkg::*;
#(
    parameter int MAX_COLUMNS    = 1024,
    parameter int ROW_INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LEN_W-1:0]      i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SYM_W-1:0]      i_symbol,
    input  logic                  i_map_start,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SIDE_W-1:0]     o_cell_side,
    output logic [SIDE_W-1:0]     o_best_side,
    output logic [ROW_OUT_W-1:0]  o_best_row,
    output logic [COL_OUT_W-1:0]  o_best_column,
    output logic                  o_row_end,
    output logic                  o_map_error
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;
    localparam int RW = ROW_INDEX_BITS;

    // configuration
    logic [SYM_W-1:0] r_obstacle_code;
    logic [SYM_W-1:0] r_empty_code;
    logic [LEN_W-1:0] r_row_length;

    // front state
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_err;

    // row buffer
    logic [SIDE_W-1:0] r_mem [MAX_COLUMNS];
    logic [SIDE_W-1:0] r_rd;
    logic              r_fwd;
    logic [SIDE_W-1:0] r_fwd_data;

    // compute stage
    logic          r_s1_valid;
    logic          r_s1_start;
    t_kind         r_s1_kind;
    logic [AW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_top;
    logic          r_s1_err;

    logic [SIDE_W-1:0] r_ul;
    logic [SIDE_W-1:0] r_left;
    logic [SIDE_W-1:0] r_best;
    logic [RW-1:0]     r_best_row;
    logic [AW-1:0]     r_best_col;

    // output register
    logic              r_out_valid;
    logic [SIDE_W-1:0] r_out_side;
    logic [SIDE_W-1:0] r_out_best;
    logic [RW-1:0]     r_out_brow;
    logic [AW-1:0]     r_out_bcol;
    logic              r_out_end;
    logic              r_out_err;

    // front decode
    logic [LW-1:0] len_eff;
    logic [CW-1:0] col_base;
    logic [RW-1:0] row_base;
    logic          err_base;
    logic          at_term;
    logic [AW-1:0] c_new;
    t_kind         n_kind;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          n_err;
    logic          accept;
    logic          new_cell;

    // compute
    logic              s1_adv;
    logic              s1_cell;
    logic [SIDE_W-1:0] above;
    logic [SIDE_W-1:0] ul_eff;
    logic [SIDE_W-1:0] m_two;
    logic [SIDE_W-1:0] m_three;
    logic [SIDE_W-1:0] side;
    logic [SIDE_W-1:0] best_base;
    logic [RW-1:0]     best_row_base;
    logic [AW-1:0]     best_col_base;
    logic [SIDE_W-1:0] n_best;
    logic [RW-1:0]     n_best_row;
    logic [AW-1:0]     n_best_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle_code <= OBSTACLE_RESET;
            r_empty_code    <= EMPTY_RESET;
            r_row_length    <= LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OBSTACLE_CODE: r_obstacle_code <= i_cfg_data[SYM_W-1:0];
                CFG_EMPTY_CODE:    r_empty_code    <= i_cfg_data[SYM_W-1:0];
                CFG_ROW_LENGTH:    r_row_length    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (r_row_length == '0) begin
            len_eff = LW'(1);
        end else if (LW'(r_row_length) > LW'(MAX_COLUMNS)) begin
            len_eff = LW'(MAX_COLUMNS);
        end else begin
            len_eff = LW'(r_row_length);
        end

        col_base = i_map_start ? '0 : r_col;
        row_base = i_map_start ? '0 : r_row;
        err_base = i_map_start ? 1'b0 : r_err;
        at_term  = LW'(col_base) >= len_eff;
        c_new    = col_base[AW-1:0];

        n_col  = col_base;
        n_row  = row_base;
        n_err  = err_base;
        n_kind = K_CELL_OBS;
        if (at_term) begin
            if (i_symbol == SYM_NEWLINE || i_symbol == SYM_NUL) begin
                n_kind = K_TERM_OK;
                n_col  = '0;
                if (row_base != '1) begin
                    n_row = row_base + RW'(1);
                end
            end else begin
                n_kind = K_TERM_BAD;
                n_err  = 1'b1;
            end
        end else begin
            n_col = col_base + CW'(1);
            if (i_symbol == r_obstacle_code) begin
                n_kind = K_CELL_OBS;
            end else if (i_symbol == r_empty_code) begin
                n_kind = K_CELL_EMPTY;
            end else begin
                n_kind = K_CELL_OBS;
                n_err  = 1'b1;
            end
        end
        new_cell = !at_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_err <= 1'b0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_err <= n_err;
        end
    end

    // side computation
    always_comb begin
        s1_cell = (r_s1_kind == K_CELL_OBS) || (r_s1_kind == K_CELL_EMPTY);
        if (r_s1_top) begin
            above = '0;
        end else if (r_fwd) begin
            above = r_fwd_data;
        end else begin
            above = r_rd;
        end
        ul_eff  = r_s1_start ? '0 : r_ul;
        m_two   = (above < r_left) ? above : r_left;
        m_three = (m_two < ul_eff) ? m_two : ul_eff;

        if (r_s1_kind == K_CELL_EMPTY) begin
            side = (r_s1_col == '0) ? SIDE_W'(1) : m_three + SIDE_W'(1);
        end else begin
            side = '0;
        end

        best_base     = r_s1_start ? '0 : r_best;
        best_row_base = r_s1_start ? '0 : r_best_row;
        best_col_base = r_s1_start ? '0 : r_best_col;
        n_best     = best_base;
        n_best_row = best_row_base;
        n_best_col = best_col_base;
        if (s1_cell && side > best_base) begin
            n_best     = side;
            n_best_row = r_s1_row;
            n_best_col = r_s1_col;
        end
    end

    // row buffer with same-column forwarding
    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_cell) begin
            r_mem[r_s1_col] <= side;
        end
        if (accept && new_cell) begin
            r_rd <= r_mem[c_new];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (accept) begin
            r_fwd <= s1_adv && s1_cell && (r_s1_col == c_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= side;
            r_s1_start <= i_map_start;
            r_s1_kind  <= n_kind;
            r_s1_col   <= c_new;
            r_s1_row   <= row_base;
            r_s1_top   <= (row_base == '0);
            r_s1_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul       <= '0;
            r_left     <= '0;
            r_best     <= '0;
            r_best_row <= '0;
            r_best_col <= '0;
        end else if (s1_adv) begin
            r_best     <= n_best;
            r_best_row <= n_best_row;
            r_best_col <= n_best_col;
            if (s1_cell) begin
                r_ul   <= above;
                r_left <= side;
            end else if (r_s1_kind == K_TERM_OK) begin
                r_ul <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_side <= side;
            r_out_best <= n_best;
            r_out_brow <= n_best_row;
            r_out_bcol <= n_best_col;
            r_out_end  <= (r_s1_kind == K_TERM_OK);
            r_out_err  <= r_s1_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cell_side   = r_out_side;
    assign o_best_side   = r_out_best;
    assign o_best_row    = ROW_OUT_W'(r_out_brow);
    assign o_best_column = COL_OUT_W'(r_out_bcol);
    assign o_row_end     = r_out_end;
    assign o_map_error   = r_out_err;

endmodule
